/* rtl/btff_pkg.sv */
`timescale 1ns / 1ps
package btff_pkg;

	// byte address arithmetic width, wide enough that no tag sum wraps
	localparam int ADDR_W      = 37;
	localparam int ASIZE_W     = 21;
	localparam int GSIZE_W     = 23;
	localparam int EXT_W       = 17;
	localparam int ALIGN_BYTES = 8;
	localparam int MIN_BLOCK   = 2 * ALIGN_BYTES;

	localparam logic [EXT_W-1:0] EXTEND_RESET = 17'd4096;
	localparam logic [31:0]      TAG_ALLOC    = 32'h1;
	localparam logic [31:0]      TAG_PROLOGUE = 32'(ALIGN_BYTES) | TAG_ALLOC;

	// register indexes on the configuration port
	typedef enum logic {
		REG_EXTEND = 1'b0,
		REG_NONE   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_NOMEM = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// truncate bytes to words, round up to an even word count, back to bytes
	function automatic logic [GSIZE_W-1:0] grow_bytes(input logic [ASIZE_W-1:0] bytes);
		logic [ASIZE_W-3:0] words;
		logic [ASIZE_W-2:0] even;
		words = bytes[ASIZE_W-1:2];
		even  = {1'b0, words} + {{(ASIZE_W-2){1'b0}}, words[0]};
		return {1'b0, even, 2'b00};
	endfunction

endpackage

/* rtl/btff_ram.sv */
`timescale 1ns / 1ps
module btff_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one word, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/btff_cfg.sv */
`timescale 1ns / 1ps
module btff_cfg
	import btff_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [EXT_W-1:0] extend_bytes
);

	logic [EXT_W-1:0] ext_q;
	reg_idx_t         idx;

	assign idx          = reg_idx_t'(paddr[2]);
	assign pready       = 1'b1;
	assign extend_bytes = ext_q;

	// take the write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= EXTEND_RESET;
		end else if (psel && penable && pwrite && idx == REG_EXTEND) begin
			ext_q <= pwdata[EXT_W-1:0];
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_EXTEND: prdata = {{(32-EXT_W){1'b0}}, ext_q};
			default:    prdata = '0;
		endcase
	end

endmodule

/* rtl/boundary_tag_first_fit_allocator.sv */
`timescale 1ns / 1ps
// Init writes the prologue and epilogue tags and grows the heap; free clears both tags and merges;
// allocate walks the blocks first fit, grows the heap when none fits, then places the block,
// splitting off a large enough rest; no-op, null free and refused allocate go to the result.
// Throughput: one request at a time, the next taken the cycle after the result is registered;
// a result held by the receiver stalls the engine. Heap tags are accessed one at a time.
// Reset clears the break, the list start and extend_bytes (to 4096); heap words stay undefined.
module boundary_tag_first_fit_allocator
	import btff_pkg::*;
#(
	parameter int HEAP_WORDS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [19:0] req_size,
	input  logic [15:0] block_ptr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] payload_addr,
	output logic [1:0]  status
);

	localparam int IDX_W = $clog2(HEAP_WORDS);
	localparam int BW    = IDX_W + 2;
	localparam int BRK_W = IDX_W + 3;
	localparam logic [ADDR_W-1:0] HEAP_BYTES = ADDR_W'(HEAP_WORDS) << 2;
	localparam int NS = 33;

	typedef enum logic [NS-1:0] {
		S_IDLE = 33'h1 << 0,  S_I0  = 33'h1 << 1,  S_I1  = 33'h1 << 2,
		S_I2   = 33'h1 << 3,  S_I3  = 33'h1 << 4,  S_G0  = 33'h1 << 5,
		S_G1   = 33'h1 << 6,  S_G2  = 33'h1 << 7,  S_M0  = 33'h1 << 8,
		S_M1   = 33'h1 << 9,  S_M2  = 33'h1 << 10, S_M3  = 33'h1 << 11,
		S_M4   = 33'h1 << 12, S_M5  = 33'h1 << 13, S_MA1 = 33'h1 << 14,
		S_MA2  = 33'h1 << 15, S_MB1 = 33'h1 << 16, S_MB2 = 33'h1 << 17,
		S_MC1  = 33'h1 << 18, S_MC2 = 33'h1 << 19, S_MR  = 33'h1 << 20,
		S_F0   = 33'h1 << 21, S_F1  = 33'h1 << 22, S_F2  = 33'h1 << 23,
		S_FF0  = 33'h1 << 24, S_FF1 = 33'h1 << 25, S_P0  = 33'h1 << 26,
		S_P1   = 33'h1 << 27, S_P2  = 33'h1 << 28, S_P3  = 33'h1 << 29,
		S_P4   = 33'h1 << 30, S_P5  = 33'h1 << 31, S_DONE = 33'h1 << 32
	} state_t;

	state_t               state_q;
	req_t                 op_q;
	logic [EXT_W-1:0]     ext_bytes;
	logic [BRK_W-1:0]     brk_q;
	logic [15:0]          ls_q;
	logic [ADDR_W-1:0]    bp_q, size_q, prev_q, next_q, r3_q;
	logic [ASIZE_W-1:0]   asize_q;
	logic [GSIZE_W-1:0]   gsize_q;
	logic                 pa_q;
	logic [15:0]          res_addr_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [15:0]          payload_addr_q;
	status_t              status_q;

	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_addr;
	logic [31:0]          mem_wdata;
	logic                 in_range;
	logic                 oob_s1;
	logic [31:0]          ram_rdata;
	logic [31:0]          tag;
	logic [ADDR_W-1:0]    tsz;
	logic [ADDR_W-1:0]    brk_ext, gsize_ext, asize_ext, ff_next;
	logic                 g_fit;
	logic                 accept;
	logic [ASIZE_W-1:0]   ext_max, req_asize, req_round;

	btff_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.extend_bytes (ext_bytes)
	);

	btff_ram #(
		.WIDTH (32),
		.DEPTH (HEAP_WORDS)
	) u_heap (
		.clk   (clk),
		.we    (mem_we && in_range),
		.addr  (mem_addr[BW-1:2]),
		.wdata (mem_wdata),
		.rdata (ram_rdata)
	);

	// tag seen from the read issued last cycle; beyond the heap it reads allocated, size 0
	assign tag       = oob_s1 ? TAG_ALLOC : ram_rdata;
	assign tsz       = {{(ADDR_W-32){1'b0}}, tag[31:3], 3'b000};
	assign in_range  = mem_addr < HEAP_BYTES;
	assign brk_ext   = ADDR_W'(brk_q);
	assign gsize_ext = ADDR_W'(gsize_q);
	assign asize_ext = ADDR_W'(asize_q);
	assign ff_next   = bp_q + tsz;
	assign g_fit     = (brk_ext + gsize_ext) <= HEAP_BYTES;
	assign ext_max   = (asize_q > ASIZE_W'(ext_bytes)) ? asize_q : ASIZE_W'(ext_bytes);
	assign req_round = ASIZE_W'(req_size) + ASIZE_W'(15);
	assign req_asize = (req_size <= 20'(ALIGN_BYTES)) ? ASIZE_W'(MIN_BLOCK)
		: {req_round[ASIZE_W-1:3], 3'b000};
	assign accept    = in_valid && in_ready;

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = out_valid_q;
	assign payload_addr = payload_addr_q;
	assign status       = status_q;

	// issue one heap read or write per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			S_I0: begin
				mem_we = 1'b1; mem_addr = ADDR_W'(0); mem_wdata = '0;
			end
			S_I1: begin
				mem_we = 1'b1; mem_addr = ADDR_W'(4); mem_wdata = TAG_PROLOGUE;
			end
			S_I2: begin
				mem_we = 1'b1; mem_addr = ADDR_W'(8); mem_wdata = TAG_PROLOGUE;
			end
			S_I3: begin
				mem_we = 1'b1; mem_addr = ADDR_W'(12); mem_wdata = TAG_ALLOC;
			end
			S_G0: begin
				mem_we    = (gsize_q != '0) && g_fit;
				mem_addr  = brk_ext - ADDR_W'(4);
				mem_wdata = 32'(gsize_q);
			end
			S_G1: begin
				mem_we = 1'b1; mem_addr = bp_q + gsize_ext - ADDR_W'(8);
				mem_wdata = 32'(gsize_q);
			end
			S_G2: begin
				mem_we = 1'b1; mem_addr = bp_q + gsize_ext - ADDR_W'(4);
				mem_wdata = TAG_ALLOC;
			end
			S_M0, S_MA1, S_F0, S_FF0, S_P0: mem_addr = bp_q - ADDR_W'(4);
			S_M1, S_MB1: mem_addr = bp_q - ADDR_W'(8);
			S_M2: mem_addr = bp_q - tsz - ADDR_W'(4);
			S_M3: mem_addr = prev_q + tsz - ADDR_W'(8);
			S_M4: mem_addr = next_q - ADDR_W'(4);
			S_M5: begin
				if (pa_q && !tag[0]) begin
					mem_we = 1'b1; mem_addr = bp_q - ADDR_W'(4);
					mem_wdata = 32'(size_q + tsz);
				end else if (!pa_q && tag[0]) begin
					mem_we = 1'b1; mem_addr = next_q - ADDR_W'(8);
					mem_wdata = 32'(size_q + r3_q);
				end else begin
					mem_addr = next_q + tsz - ADDR_W'(8);
				end
			end
			S_MA2: begin
				mem_we = 1'b1; mem_addr = bp_q + tsz - ADDR_W'(8);
				mem_wdata = 32'(size_q);
			end
			S_MB2: begin
				mem_we = 1'b1; mem_addr = bp_q - tsz - ADDR_W'(4);
				mem_wdata = 32'(size_q);
			end
			S_MC2: begin
				mem_we = 1'b1; mem_addr = next_q; mem_wdata = 32'(size_q);
			end
			S_F1: begin
				mem_we = 1'b1; mem_addr = bp_q - ADDR_W'(4); mem_wdata = 32'(tsz);
			end
			S_F2: begin
				mem_we = 1'b1; mem_addr = bp_q + size_q - ADDR_W'(8);
				mem_wdata = 32'(size_q);
			end
			S_FF1: mem_addr = ff_next - ADDR_W'(4);
			S_P1: begin
				mem_we   = 1'b1;
				mem_addr = bp_q - ADDR_W'(4);
				if (tsz >= asize_ext + ADDR_W'(MIN_BLOCK)) begin
					mem_wdata = 32'(asize_q) | TAG_ALLOC;
				end else begin
					mem_wdata = 32'(tsz) | TAG_ALLOC;
				end
			end
			S_P2: begin
				mem_we = 1'b1; mem_addr = bp_q + asize_ext - ADDR_W'(8);
				mem_wdata = 32'(asize_q) | TAG_ALLOC;
			end
			S_P3: begin
				mem_we = 1'b1; mem_addr = bp_q + asize_ext - ADDR_W'(4);
				mem_wdata = 32'(size_q - asize_ext);
			end
			S_P4: begin
				mem_we = 1'b1; mem_addr = bp_q + size_q - ADDR_W'(8);
				mem_wdata = 32'(size_q - asize_ext);
			end
			S_P5: begin
				mem_we = 1'b1; mem_addr = bp_q + size_q - ADDR_W'(8);
				mem_wdata = 32'(size_q) | TAG_ALLOC;
			end
			default: ;
		endcase
	end

	// track whether the read in flight fell outside the heap
	always_ff @(posedge clk) begin
		oob_s1 <= !in_range;
	end

	// sequence the request and hold its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			brk_q          <= '0;
			ls_q           <= '0;
			out_valid_q    <= 1'b0;
			op_q           <= REQ_NOP;
			res_addr_q     <= '0;
			res_status_q   <= ST_OK;
			payload_addr_q <= '0;
			status_q       <= ST_OK;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= req_t'(req_type);
						res_addr_q <= '0;
						asize_q    <= req_asize;
						case (req_t'(req_type))
							REQ_INIT: begin
								res_status_q <= ST_OK;
								state_q      <= S_I0;
							end
							REQ_ALLOC: begin
								if (req_size == '0) begin
									res_status_q <= ST_ZERO;
									state_q      <= S_DONE;
								end else if (ls_q == '0) begin
									res_status_q <= ST_NOMEM;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									bp_q         <= ADDR_W'(ls_q);
									state_q      <= S_FF0;
								end
							end
							REQ_FREE: begin
								res_status_q <= ST_OK;
								if (block_ptr != '0 && ls_q != '0) begin
									bp_q    <= ADDR_W'(block_ptr);
									state_q <= S_F0;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_I0: begin
					brk_q   <= '0;
					state_q <= S_I1;
				end
				S_I1: state_q <= S_I2;
				S_I2: state_q <= S_I3;
				S_I3: begin
					brk_q   <= BRK_W'(16);
					ls_q    <= 16'd8;
					gsize_q <= grow_bytes(ASIZE_W'(ext_bytes));
					state_q <= S_G0;
				end
				// grow: size zero succeeds with no block, past the limit fails
				S_G0: begin
					if (gsize_q == '0) begin
						bp_q    <= '0;
						state_q <= S_MR;
					end else if (!g_fit) begin
						res_status_q <= ST_NOMEM;
						state_q      <= S_DONE;
					end else begin
						bp_q    <= brk_ext;
						state_q <= S_G1;
					end
				end
				S_G1: state_q <= S_G2;
				S_G2: begin
					brk_q   <= BRK_W'(bp_q + gsize_ext);
					state_q <= S_M0;
				end
				// coalesce with neighbours
				S_M0: state_q <= S_M1;
				S_M1: begin
					size_q  <= tsz;
					state_q <= S_M2;
				end
				S_M2: begin
					prev_q  <= bp_q - tsz;
					next_q  <= bp_q + size_q;
					state_q <= S_M3;
				end
				S_M3: begin
					r3_q    <= tsz;
					state_q <= S_M4;
				end
				S_M4: begin
					pa_q    <= tag[0];
					state_q <= S_M5;
				end
				S_M5: begin
					if (pa_q && tag[0]) begin
						state_q <= S_MR;
					end else if (pa_q) begin
						size_q  <= size_q + tsz;
						state_q <= S_MA1;
					end else if (tag[0]) begin
						size_q  <= size_q + r3_q;
						state_q <= S_MB1;
					end else begin
						next_q  <= next_q + tsz - ADDR_W'(8);
						state_q <= S_MC1;
					end
				end
				S_MA1: state_q <= S_MA2;
				S_MA2: state_q <= S_MR;
				S_MB1: state_q <= S_MB2;
				S_MB2: begin
					bp_q    <= bp_q - tsz;
					state_q <= S_MR;
				end
				S_MC1: begin
					size_q  <= size_q + tsz + r3_q;
					state_q <= S_MC2;
				end
				S_MC2: state_q <= S_MB1;
				// hand the merged block back to the request
				S_MR: begin
					if (op_q == REQ_ALLOC && bp_q != '0) begin
						state_q <= S_P0;
					end else begin
						state_q <= S_DONE;
						if (op_q == REQ_ALLOC) begin
							res_status_q <= ST_NOMEM;
						end
					end
				end
				// free: clear both tags, then merge
				S_F0: state_q <= S_F1;
				S_F1: begin
					size_q  <= tsz;
					state_q <= S_F2;
				end
				S_F2: state_q <= S_M0;
				// first-fit walk, one block a cycle
				S_FF0: begin
					if (bp_q <= brk_ext) begin
						state_q <= S_FF1;
					end else begin
						gsize_q <= grow_bytes(ext_max);
						state_q <= S_G0;
					end
				end
				S_FF1: begin
					if (tsz == '0) begin
						gsize_q <= grow_bytes(ext_max);
						state_q <= S_G0;
					end else if (!tag[0] && asize_ext <= tsz) begin
						state_q <= S_P0;
					end else begin
						bp_q <= ff_next;
						if (ff_next > brk_ext) begin
							gsize_q <= grow_bytes(ext_max);
							state_q <= S_G0;
						end
					end
				end
				// place the block, splitting off a large enough rest
				S_P0: state_q <= S_P1;
				S_P1: begin
					size_q <= tsz;
					if (tsz >= asize_ext + ADDR_W'(MIN_BLOCK)) begin
						state_q <= S_P2;
					end else begin
						state_q <= S_P5;
					end
				end
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4, S_P5: begin
					res_addr_q <= bp_q[15:0];
					state_q    <= S_DONE;
				end
				// hand the result over once the output slot is free
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						payload_addr_q <= res_addr_q;
						status_q       <= res_status_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_brk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		brk_ext <= HEAP_BYTES)
		else $error("break beyond heap");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted but engine stayed idle");

	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && payload_addr_q != '0 |-> status_q == ST_OK)
		else $error("address returned with failing status");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !out_valid_q |=> out_valid_q)
		else $error("finished result not presented");

endmodule
